// ===== rtl/core/dotq_pkg.sv =====
package dotq_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int ID_COUNT       = 16;

  localparam int FUNC_W  = 2;
  localparam int ID_W    = 4;
  localparam int DELAY_W = 32;
  localparam int TIME_W  = 60;
  localparam int DL_W    = 61;
  localparam int KIND_W  = 3;

  localparam logic [DL_W-1:0] NEVER_TIME = {1'b1, {TIME_W{1'b0}}};

  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_STARTED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START_REJ   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CANCEL_IDLE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE        = 3'd5;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] dl;
    logic [ID_W-1:0]   owner;
  } entry_t;

  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              pop;
    logic [TIME_W-1:0] key;
    logic [ID_W-1:0]   id;
  } cell_cmd_t;

endpackage

// ===== rtl/core/dotq_cell.sv =====
module dotq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dotq_pkg::cell_cmd_t cmd_i,
  input  dotq_pkg::entry_t   left_i,
  input  dotq_pkg::entry_t   right_i,
  input  logic               goes_left_i,
  input  logic               hit_left_i,
  output dotq_pkg::entry_t   entry_o,
  output logic               goes_o,
  output logic               hit_o
);
  import dotq_pkg::*;

  logic              valid_q, valid_d;
  logic [TIME_W-1:0] dl_q, dl_d;
  logic [ID_W-1:0]   owner_q, owner_d;
  logic              take;
  logic              le;

  always_comb begin
    le     = valid_q && (dl_q <= cmd_i.key);
    goes_o = !le;
    hit_o  = hit_left_i | (cmd_i.rem && (cmd_i.pop || (valid_q && (owner_q == cmd_i.id))));
  end

  always_comb begin
    take    = 1'b0;
    valid_d = valid_q;
    dl_d    = dl_q;
    owner_d = owner_q;
    if (cmd_i.ins && goes_o) begin
      take = 1'b1;
      if (goes_left_i) begin
        valid_d = left_i.valid;
        dl_d    = left_i.dl;
        owner_d = left_i.owner;
      end else begin
        valid_d = 1'b1;
        dl_d    = cmd_i.key;
        owner_d = cmd_i.id;
      end
    end else if (cmd_i.rem && hit_o) begin
      take    = 1'b1;
      valid_d = right_i.valid;
      dl_d    = right_i.dl;
      owner_d = right_i.owner;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      dl_q    <= dl_d;
      owner_q <= owner_d;
    end
  end

  assign entry_o = '{valid: valid_q, dl: dl_q, owner: owner_q};

endmodule

// ===== rtl/core/deadline_ordered_timer_queue.sv =====
// Channel  Dir  Signals                       Contents
// s_axis   in   tvalid tready tdata tuser     request: func, timer id, delay, new time
// m_axis   out  tvalid tready tdata tuser     result: kind, timer, next deadline, last
//
// Start and cancel go through IDLE, which takes the request, and EXEC, which updates the
// chain of cells and loads the result. After IDLE takes a tick, TICK pops the head cell
// once a cycle while the output is free, one result per pop (a none result if no cell
// is due). A stalled output holds the chain. Reset clears the cells' valid bits, the
// running bits and the time; no clearing pass follows.
module deadline_ordered_timer_queue #(
  parameter int NUM_TIMERS = dotq_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // timer_id[3:0], delay_ms[35:4], now_ms[95:36]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // event_timer[3:0], next_deadline[64:4], zero[71:65]
  output logic [2:0]  m_axis_tuser,  // event_kind[2:0]
  output logic        m_axis_tlast   // last
);
  import dotq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [FUNC_W-1:0]   func_q;
  logic [ID_W-1:0]     id_q;
  logic [TIME_W-1:0]   dl_q;
  logic [TIME_W-1:0]   cur_q;
  logic [ID_COUNT-1:0] running_q, running_d;

  logic                m_valid_q;
  logic [KIND_W-1:0]   m_kind_q, m_kind_d;
  logic [ID_W-1:0]     m_timer_q, m_timer_d;
  logic [DL_W-1:0]     m_next_q, m_next_d;
  logic                m_last_q, m_last_d;
  logic                emit;

  logic                in_acc;
  logic                out_free;
  logic [DL_W-1:0]     sum;
  logic [TIME_W-1:0]   dl_new;
  logic                id_ok;

  cell_cmd_t           cmd;
  entry_t              cell_e [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] goes, hit, cell_valid;
  logic [DL_W-1:0]     head_next, second_next;
  logic [TIME_W-1:0]   key;
  logic                head_le, second_le, head_hit;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign sum    = {1'b0, cur_q} + DL_W'(s_axis_tdata[35:4]);
  assign dl_new = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  assign id_ok  = (32'(id_q) < NUM_TIMERS);

  assign head_next   = cell_e[0].valid ? {1'b0, cell_e[0].dl} : NEVER_TIME;
  assign second_next = cell_e[1].valid ? {1'b0, cell_e[1].dl} : NEVER_TIME;

  assign key       = (state_q == ST_TICK) ? cur_q : dl_q;
  assign head_le   = cell_e[0].valid && (cell_e[0].dl <= key);
  assign second_le = cell_e[1].valid && (cell_e[1].dl <= key);
  assign head_hit  = cell_e[0].valid && (cell_e[0].owner == id_q);

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   goes_l, hit_l;
    if (i == 0) begin : g_first
      assign left_e = '0;
      assign goes_l = 1'b0;
      assign hit_l  = 1'b0;
    end else begin : g_mid
      assign left_e = cell_e[i-1];
      assign goes_l = goes[i-1];
      assign hit_l  = hit[i-1];
    end
    if (i == NUM_TIMERS - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_e[i+1];
    end
    dotq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left_e),
      .right_i     (right_e),
      .goes_left_i (goes_l),
      .hit_left_i  (hit_l),
      .entry_o     (cell_e[i]),
      .goes_o      (goes[i]),
      .hit_o       (hit[i])
    );
    assign cell_valid[i] = cell_e[i].valid;
  end

  always_comb begin
    state_d   = state_q;
    running_d = running_q;
    emit      = 1'b0;
    m_kind_d  = m_kind_q;
    m_timer_d = m_timer_q;
    m_next_d  = m_next_q;
    m_last_d  = 1'b1;
    cmd       = '{ins: 1'b0, rem: 1'b0, pop: 1'b0, key: key, id: id_q};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == FUNC_TICK) begin
            state_d = ST_TICK;
          end else if (s_axis_tuser == FUNC_START || s_axis_tuser == FUNC_CANCEL) begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          emit      = 1'b1;
          m_timer_d = id_q;
          state_d   = ST_IDLE;
          if (func_q == FUNC_START) begin
            if (!id_ok || running_q[id_q] || cell_valid[NUM_TIMERS-1]) begin
              m_kind_d = KIND_START_REJ;
              m_next_d = head_next;
            end else begin
              cmd.ins           = 1'b1;
              running_d[id_q]   = 1'b1;
              m_kind_d          = KIND_STARTED;
              m_next_d          = head_le ? head_next : {1'b0, dl_q};
            end
          end else begin
            if (!id_ok || !running_q[id_q]) begin
              m_kind_d = KIND_CANCEL_IDLE;
              m_next_d = head_next;
            end else begin
              cmd.rem         = 1'b1;
              running_d[id_q] = 1'b0;
              m_kind_d        = KIND_CANCELLED;
              m_next_d        = head_hit ? second_next : head_next;
            end
          end
        end
      end
      ST_TICK: begin
        if (out_free) begin
          emit = 1'b1;
          if (head_le) begin
            cmd.rem                   = 1'b1;
            cmd.pop                   = 1'b1;
            running_d[cell_e[0].owner] = 1'b0;
            m_kind_d                  = KIND_EXPIRED;
            m_timer_d                 = cell_e[0].owner;
            m_next_d                  = second_next;
            m_last_d                  = !second_le;
            if (!second_le) begin
              state_d = ST_IDLE;
            end
          end else begin
            m_kind_d  = KIND_NONE;
            m_timer_d = '0;
            m_next_d  = head_next;
            state_d   = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      running_q <= '0;
      cur_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      if (in_acc && s_axis_tuser == FUNC_TICK) begin
        cur_q <= s_axis_tdata[95:36];
      end
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= s_axis_tuser;
      id_q   <= s_axis_tdata[3:0];
      dl_q   <= dl_new;
    end
    if (emit) begin
      m_kind_q  <= m_kind_d;
      m_timer_q <= m_timer_d;
      m_next_q  <= m_next_d;
      m_last_q  <= m_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = {7'd0, m_next_q, m_timer_q};
  assign m_axis_tlast  = m_last_q;

  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("valid cells not a prefix");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == $countones(running_q))
    else $error("queue length differs from running timers");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_e[1].valid |-> (cell_e[0].dl <= cell_e[1].dl))
    else $error("head cells out of order");

  a_notlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == KIND_EXPIRED))
    else $error("non-final result that is not an expiry");

endmodule

// ===== test/deadline_ordered_timer_queue_test.sv =====
`timescale 1ns / 100ps

module deadline_ordered_timer_queue_test;
  import dotq_pkg::*;

  localparam int SLOTS        = NUM_TIMERS_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 125;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 30;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
  localparam logic [DELAY_W-1:0] DELAY_MAX  = {DELAY_W{1'b1}};

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay_ms;
    logic [TIME_W-1:0]  now_ms;
  } timer_request_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   timer;
    logic [DL_W-1:0]   next_dl;
    logic              last;
  } timer_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // timer_id[3:0], delay_ms[35:4], now_ms[95:36]
  logic [1:0]  s_axis_tuser = '0;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // event_timer[3:0], next_deadline[64:4], zero[71:65]
  logic [2:0]  m_axis_tuser;        // event_kind[2:0]
  logic        m_axis_tlast;

  deadline_ordered_timer_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  timer_request_t    request_queue[$];
  timer_event_t      expected_events[$];
  logic [DL_W-1:0]   slot_dl[SLOTS];
  logic [ID_W-1:0]   slot_id[SLOTS];
  int                slot_count = 0;
  logic              armed[ID_COUNT];
  logic [TIME_W-1:0] clock_ms = '0;
  logic [TIME_W-1:0] gen_time = '0;
  int                error_count = 0;
  int                results_seen = 0;
  int                cycle_count = 0;

  initial begin
    for (int i = 0; i < ID_COUNT; i++) armed[i] = 1'b0;
  end

  function automatic logic [DL_W-1:0] head_deadline();
    return (slot_count > 0) ? slot_dl[0] : NEVER_TIME;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  function automatic int draw_wait(logic calm);
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic push_event(logic [KIND_W-1:0] kind, logic [ID_W-1:0] timer, logic last);
    timer_event_t ev;
    ev.kind    = kind;
    ev.timer   = timer;
    ev.next_dl = head_deadline();
    ev.last    = last;
    expected_events.push_back(ev);
  endtask

  task automatic drop_slot(int pos);
    for (int i = pos; i + 1 < slot_count; i++) begin
      slot_dl[i] = slot_dl[i+1];
      slot_id[i] = slot_id[i+1];
    end
    slot_count--;
  endtask

  function automatic logic head_due();
    return slot_count > 0 && slot_dl[0] <= {1'b0, clock_ms};
  endfunction

  task automatic apply_request(timer_request_t req);
    logic [DL_W-1:0] dl;
    logic [ID_W-1:0] owner;
    int              pos;
    int              fired;
    case (req.func)
      FUNC_START: begin
        if (armed[req.id] || slot_count >= SLOTS) begin
          push_event(KIND_START_REJ, req.id, 1'b1);
        end else begin
          dl = {1'b0, clock_ms} + {{(DL_W-DELAY_W){1'b0}}, req.delay_ms};
          if (dl >= NEVER_TIME) dl = NEVER_TIME - 1;
          pos = 0;
          while (pos < slot_count && slot_dl[pos] <= dl) pos++;
          for (int i = slot_count; i > pos; i--) begin
            slot_dl[i] = slot_dl[i-1];
            slot_id[i] = slot_id[i-1];
          end
          slot_dl[pos] = dl;
          slot_id[pos] = req.id;
          slot_count++;
          armed[req.id] = 1'b1;
          push_event(KIND_STARTED, req.id, 1'b1);
        end
      end
      FUNC_CANCEL: begin
        if (!armed[req.id]) begin
          push_event(KIND_CANCEL_IDLE, req.id, 1'b1);
        end else begin
          pos = 0;
          while (pos < slot_count && slot_id[pos] != req.id) pos++;
          if (pos < slot_count) drop_slot(pos);
          armed[req.id] = 1'b0;
          push_event(KIND_CANCELLED, req.id, 1'b1);
        end
      end
      FUNC_TICK: begin
        clock_ms = req.now_ms;
        fired = 0;
        while (head_due() && fired < ID_COUNT) begin
          owner = slot_id[0];
          armed[owner] = 1'b0;
          drop_slot(0);
          fired++;
          push_event(KIND_EXPIRED, owner, !(head_due() && fired < ID_COUNT));
        end
        if (fired == 0) push_event(KIND_NONE, '0, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic check_event(timer_event_t got);
    timer_event_t want;
    if (expected_events.size() == 0) begin
      $display("%0t unexpected result: expected none, actual kind %0d timer %0d next %0h last %0b",
               $time, got.kind, got.timer, got.next_dl, got.last);
      error_count++;
    end else begin
      want = expected_events.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t event_kind: expected %0d actual %0d", $time, want.kind, got.kind);
        error_count++;
      end
      if (got.timer !== want.timer) begin
        $display("%0t event_timer: expected %0d actual %0d", $time, want.timer, got.timer);
        error_count++;
      end
      if (got.next_dl !== want.next_dl) begin
        $display("%0t next_deadline: expected %0h actual %0h", $time, want.next_dl, got.next_dl);
        error_count++;
      end
      if (got.last !== want.last) begin
        $display("%0t last: expected %0b actual %0b", $time, want.last, got.last);
        error_count++;
      end
    end
  endtask

  task automatic add_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                             logic [DELAY_W-1:0] delay_ms, logic [TIME_W-1:0] now_ms);
    timer_request_t req;
    req.func     = func;
    req.id       = id;
    req.delay_ms = delay_ms;
    req.now_ms   = now_ms;
    if (func == FUNC_TICK) gen_time = now_ms;
    request_queue.push_back(req);
  endtask

  // driver
  timer_request_t offered;
  int             send_wait = 0;
  logic           send_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_request(offered);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          offered = request_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {offered.now_ms, offered.delay_ms, offered.id};
          s_axis_tuser  <= offered.func;
          if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
          send_wait = draw_wait(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int           recv_wait = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;
  logic         recv_calm = 1'b0;
  timer_event_t seen;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind    = m_axis_tuser;
        seen.timer   = m_axis_tdata[3:0];
        seen.next_dl = m_axis_tdata[64:4];
        seen.last    = m_axis_tlast;
        check_event(seen);
        results_seen++;
        if ($urandom_range(0, 19) == 0) recv_calm = !recv_calm;
        recv_wait = draw_wait(recv_calm);
        if (results_seen == HOLD_AT && !hold_done) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("deadline_ordered_timer_queue verification failed");
      $finish;
    end
  end

  initial begin
    int                 random_count;
    int                 choice;
    int                 r;
    logic [DELAY_W-1:0] dly;
    logic [TIME_W-1:0]  tnow;

    // directed
    add_request(FUNC_TICK, 4'd7, $urandom, '0);
    add_request(FUNC_CANCEL, 4'd3, $urandom, rand_time());
    add_request(FUNC_START, 4'd0, '0, rand_time());
    add_request(FUNC_START, 4'd1, '0, rand_time());
    add_request(FUNC_START, 4'd0, 32'd9, rand_time());
    add_request(FUNC_START, 4'd2, DELAY_MAX, rand_time());
    add_request(FUNC_START, 4'd3, 32'd5, rand_time());
    add_request(FUNC_CANCEL, 4'd3, $urandom, rand_time());
    add_request(FUNC_UNUSED, 4'd15, DELAY_MAX, TIME_MAX);
    add_request(FUNC_TICK, 4'd15, DELAY_MAX, '0);
    add_request(FUNC_TICK, 4'd0, '0, TIME_MAX);
    add_request(FUNC_START, 4'd4, DELAY_MAX, '0);
    add_request(FUNC_START, 4'd5, '0, TIME_MAX);
    add_request(FUNC_START, 4'd15, 32'd1, '0);
    add_request(FUNC_TICK, 4'd9, $urandom, 60'd100);
    add_request(FUNC_CANCEL, 4'd4, $urandom, rand_time());
    add_request(FUNC_CANCEL, 4'd15, $urandom, rand_time());
    add_request(FUNC_TICK, 4'd2, $urandom, TIME_MAX);
    add_request(FUNC_TICK, 4'd2, $urandom, 60'd0);

    // random
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 99);
      if (choice < 4) begin
        // start every timer id with a short delay, then one tick meant to expire them all
        for (int k = 0; k < ID_COUNT; k++)
          add_request(FUNC_START, k[ID_W-1:0], $urandom_range(0, 30), rand_time());
        add_request(FUNC_TICK, ID_W'($urandom_range(0, 15)), $urandom, gen_time + 60'd200);
        random_count += ID_COUNT + 1;
      end else if (choice < 50) begin
        r = $urandom_range(0, 9);
        if (r < 7) dly = $urandom_range(0, 100);
        else if (r < 9) dly = $urandom;
        else dly = DELAY_MAX;
        add_request(FUNC_START, ID_W'($urandom_range(0, 15)), dly, rand_time());
        random_count++;
      end else if (choice < 68) begin
        add_request(FUNC_CANCEL, ID_W'($urandom_range(0, 15)), $urandom, rand_time());
        random_count++;
      end else if (choice < 96) begin
        r = $urandom_range(0, 19);
        case (r)
          0: tnow = rand_time();
          1: tnow = gen_time - $urandom_range(1, 50);
          2: tnow = TIME_MAX;
          3: tnow = TIME_W'($urandom_range(0, 1000));
          default: tnow = gen_time + $urandom_range(0, 80);
        endcase
        add_request(FUNC_TICK, ID_W'($urandom_range(0, 15)), $urandom, tnow);
        random_count++;
      end else begin
        add_request(FUNC_UNUSED, ID_W'($urandom_range(0, 15)), $urandom, rand_time());
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_events.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_events.size() > 0) error_count++;
    if (error_count == 0) begin
      $display("deadline_ordered_timer_queue verification clean");
    end else begin
      $display("deadline_ordered_timer_queue verification failed");
    end
    $finish;
  end

endmodule
